FILE: hw/rtl/jtl_pkg.sv
// Shared types and constants for the JSON token lexer.
package jtl_pkg;

  localparam int unsigned PosWidth = 16;
  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  typedef enum logic [3:0] {
    TokLbrace   = 4'd0,
    TokRbrace   = 4'd1,
    TokLbracket = 4'd2,
    TokRbracket = 4'd3,
    TokColon    = 4'd4,
    TokComma    = 4'd5,
    TokString   = 4'd6,
    TokError    = 4'd7,
    TokEof      = 4'd8
  } token_kind_e;

  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChLbrace = 8'h7b;
  localparam logic [7:0] ChRbrace = 8'h7d;
  localparam logic [7:0] ChLbrack = 8'h5b;
  localparam logic [7:0] ChRbrack = 8'h5d;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChDig0   = 8'h30;
  localparam logic [7:0] ChDig9   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7a;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;

  typedef struct packed {
    token_kind_e         kind;
    logic [PosWidth-1:0] start;
    logic [PosWidth-1:0] length;
    logic [PosWidth-1:0] row;
    logic [PosWidth-1:0] column;
    logic                last;
  } token_t;

endpackage

FILE: hw/rtl/json_token_lexer_core.sv
// JSON token lexer: one byte per cycle in unless stalled; tokens out via a queue.
//
// Input channel (in_valid_i / in_ready_o): one text byte per transaction, or an
// end marker with no byte. Output channel (out_valid_o / out_ready_i): one token
// per transaction with kind, start offset, length, row, column and last_of_run.
// The lexer state and the token fields are worked out in the cycle the
// transaction is accepted and registered into a four-entry result queue; a
// token is offered on the output once the tokens ahead of it have been taken.
// With the receiver ready the block sustains one byte per cycle. An end marker
// with a string still open yields two tokens (error, then eof), and the queue
// absorbs the extra one.
// in_ready_o stays high while the queue has room for two tokens, so a stalled
// receiver fills the queue and then holds off the sender; nothing is dropped.
// Reset clears the queue, sets offset to 0, row and column to 1 and leaves the
// lexer outside any string. Offset, row and column saturate at their maximum.
module json_token_lexer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    text_byte_i,
  input  logic                          end_marker_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    token_kind_o,
  output logic [jtl_pkg::PosWidth-1:0]  token_start_o,
  output logic [jtl_pkg::PosWidth-1:0]  token_length_o,
  output logic [jtl_pkg::PosWidth-1:0]  token_row_o,
  output logic [jtl_pkg::PosWidth-1:0]  token_column_o,
  output logic                          last_of_run_o
);

  localparam int unsigned PW = jtl_pkg::PosWidth;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v == jtl_pkg::PosMax) ? v : v + 1'b1;
  endfunction

  logic [PW-1:0] offset_q, offset_d;
  logic [PW-1:0] row_q, row_d;
  logic [PW-1:0] col_q, col_d;
  logic [PW-1:0] str_begin_q, str_begin_d;
  logic          in_str_q, in_str_d;
  logic          esc_q, esc_d;

  jtl_pkg::token_t             fifo_q [jtl_pkg::FifoDepth];
  logic [jtl_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [jtl_pkg::FifoCntW-1:0] count_q;

  jtl_pkg::token_t res0, res1;
  logic [1:0]      push_n;
  logic            accept, pop;
  logic [7:0]      b;
  logic            is_ws, is_stub;
  logic [PW-1:0]   str_len;

  assign in_ready_o  = (count_q <= jtl_pkg::FifoCntW'(jtl_pkg::FifoDepth - 2));
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  assign b       = text_byte_i;
  assign is_ws   = (b == jtl_pkg::ChSpace) || (b == jtl_pkg::ChTab) ||
                   (b == jtl_pkg::ChCr) || (b == jtl_pkg::ChLf);
  assign is_stub = (b == jtl_pkg::ChMinus) ||
                   (b >= jtl_pkg::ChDig0 && b <= jtl_pkg::ChDig9) ||
                   (b >= jtl_pkg::ChLowA && b <= jtl_pkg::ChLowZ) ||
                   (b >= jtl_pkg::ChUpA && b <= jtl_pkg::ChUpZ);
  assign str_len = offset_q - str_begin_q;

  always_comb begin
    logic advance;
    advance     = 1'b0;
    offset_d    = offset_q;
    row_d       = row_q;
    col_d       = col_q;
    str_begin_d = str_begin_q;
    in_str_d    = in_str_q;
    esc_d       = esc_q;
    push_n      = 2'd0;
    res0        = '{kind: jtl_pkg::TokError, start: offset_q, length: '0,
                    row: row_q, column: col_q, last: 1'b1};
    res1        = '{kind: jtl_pkg::TokEof, start: offset_q, length: '0,
                    row: row_q, column: col_q, last: 1'b1};

    if (end_marker_i) begin
      in_str_d = 1'b0;
      esc_d    = 1'b0;
      if (in_str_q) begin
        res0.start  = str_begin_q;
        res0.length = str_len;
        res0.last   = 1'b0;
        push_n      = 2'd2;
      end else begin
        res0   = res1;
        push_n = 2'd1;
      end
    end else if (in_str_q) begin
      advance = 1'b1;
      if (esc_q) begin
        esc_d = 1'b0;
      end else if (b == jtl_pkg::ChQuote) begin
        res0.kind   = jtl_pkg::TokString;
        res0.start  = str_begin_q;
        res0.length = str_len;
        push_n      = 2'd1;
        in_str_d    = 1'b0;
      end else if (b == jtl_pkg::ChBslash) begin
        esc_d = 1'b1;
      end
    end else if (is_ws) begin
      advance = 1'b1;
    end else if (b == jtl_pkg::ChQuote) begin
      advance     = 1'b1;
      str_begin_d = sat_inc(offset_q);
      in_str_d    = 1'b1;
      esc_d       = 1'b0;
    end else begin
      advance     = 1'b1;
      push_n      = 2'd1;
      res0.length = PW'(1);
      case (b)
        jtl_pkg::ChLbrace: res0.kind = jtl_pkg::TokLbrace;
        jtl_pkg::ChRbrace: res0.kind = jtl_pkg::TokRbrace;
        jtl_pkg::ChLbrack: res0.kind = jtl_pkg::TokLbracket;
        jtl_pkg::ChRbrack: res0.kind = jtl_pkg::TokRbracket;
        jtl_pkg::ChColon:  res0.kind = jtl_pkg::TokColon;
        jtl_pkg::ChComma:  res0.kind = jtl_pkg::TokComma;
        default: begin
          res0.kind = jtl_pkg::TokError;
          if (is_stub) res0.length = '0;
        end
      endcase
    end

    if (advance) begin
      offset_d = sat_inc(offset_q);
      if (b == jtl_pkg::ChLf) begin
        row_d = sat_inc(row_q);
        col_d = PW'(1);
      end else begin
        col_d = sat_inc(col_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      row_q       <= PW'(1);
      col_q       <= PW'(1);
      str_begin_q <= '0;
      in_str_q    <= 1'b0;
      esc_q       <= 1'b0;
    end else if (accept) begin
      offset_q    <= offset_d;
      row_q       <= row_d;
      col_q       <= col_d;
      str_begin_q <= str_begin_d;
      in_str_q    <= in_str_d;
      esc_q       <= esc_d;
    end
  end

  // Result queue storage: up to two tokens written per accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept && push_n != 2'd0) fifo_q[wr_ptr_q] <= res0;
    if (accept && push_n == 2'd2) fifo_q[wr_ptr_q + 1'b1] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) wr_ptr_q <= wr_ptr_q + jtl_pkg::FifoPtrW'(push_n);
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (accept ? jtl_pkg::FifoCntW'(push_n) : '0)
                 - jtl_pkg::FifoCntW'(pop);
    end
  end

  assign token_kind_o   = fifo_q[rd_ptr_q].kind;
  assign token_start_o  = fifo_q[rd_ptr_q].start;
  assign token_length_o = fifo_q[rd_ptr_q].length;
  assign token_row_o    = fifo_q[rd_ptr_q].row;
  assign token_column_o = fifo_q[rd_ptr_q].column;
  assign last_of_run_o  = fifo_q[rd_ptr_q].last;

endmodule
